>>> sv/tws_pkg.sv
// Shared types, codes and helpers for the three-wire serial register master.
package tws_pkg;

   // Command codes
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_WRITE  = 3'd1;
   localparam logic [2:0] CMD_READ   = 3'd2;
   localparam logic [2:0] CMD_MUTE   = 3'd3;
   localparam logic [2:0] CMD_UNMUTE = 3'd4;

   // Sequencer phase codes
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_SETUP    = 3'd1;
   localparam logic [2:0] PH_SEND_LO  = 3'd2;
   localparam logic [2:0] PH_SEND_HI  = 3'd3;
   localparam logic [2:0] PH_DUMMY_LO = 3'd4;
   localparam logic [2:0] PH_DUMMY_HI = 3'd5;
   localparam logic [2:0] PH_RECV_LO  = 3'd6;
   localparam logic [2:0] PH_RECV_HI  = 3'd7;

   // Register byte masks for write and read
   localparam logic [7:0] WR_CLEAR_MASK = 8'b11111011;
   localparam logic [7:0] RD_SET_MASK   = 8'b00000100;

   // Configuration register indexes and reset values
   localparam logic [1:0] CSR_CS_SETUP    = 2'd0;
   localparam logic [1:0] CSR_HALF_PERIOD = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_OFS  = 2'd2;

   localparam logic [7:0] CS_SETUP_RESET    = 8'd10;
   localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
   localparam logic [7:0] SAMPLE_OFS_RESET  = 8'd3;

   // Bits shifted per direction
   localparam logic [4:0] WRITE_BITS = 5'd16;
   localparam logic [4:0] READ_BITS  = 5'd8;

   typedef struct packed {
      logic [7:0] cs_setup_ticks;
      logic [7:0] half_period_ticks;
      logic [7:0] sample_offset_ticks;
   } cfg_type;

   typedef struct packed {
      logic       serial_in;
      logic [7:0] write_data;
      logic [7:0] reg_addr;
      logic [2:0] command;
   } item_type;

   typedef struct packed {
      logic       read_done;
      logic [7:0] read_data;
      logic       busy_res;
      logic       mute_n;
      logic       serial_drive;
      logic       serial_out;
      logic       serial_clock;
      logic       chip_select_n;
   } result_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [7:0]  tick_count;
      logic [3:0]  bit_count;
      logic [15:0] out_shift;
      logic [7:0]  in_shift;
      logic        is_read;
      logic        mute_level;
      logic [7:0]  last_read;
   } state_type;

   // Treat a zero length as one tick
   function automatic logic [7:0] at_least_one(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

   // True when the tick after count closes a stretch of len ticks
   function automatic logic stretch_end(input logic [7:0] count, input logic [7:0] len);
      return ({1'b0, count} + 9'd1) >= {1'b0, len};
   endfunction

endpackage

>>> sv/three_wire_serial_register_master.sv
// Top level: stream ports, config registers, sequencer state and result register.
// The input register holds an accepted transaction; its result is then registered.
// Throughput: one transaction per cycle unless stalled; the step logic is single-tick.
// Backpressure on the result side stalls the input register, and with it the input.
// Reset (synchronous, active high) returns the sequencer to idle, unmutes,
// clears the read latch and loads the timing registers with their defaults.
module three_wire_serial_register_master (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // command[2:0], reg_addr[10:3], write_data[18:11],
                                   // serial_in[19], zero fill [23:20]
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // chip_select_n[0], serial_clock[1], serial_out[2],
                                   // serial_drive[3], mute_n[4], busy_res[5],
                                   // read_data[13:6], read_done[14], zero fill [15]
   // Configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   tws_pkg::cfg_type    cfg_ff;
   tws_pkg::state_type  state_ff;
   tws_pkg::state_type  state_in;
   tws_pkg::item_type   item_ff;
   tws_pkg::result_type result_in;
   tws_pkg::result_type result_ff;
   logic                item_valid_ff;
   logic                rsp_valid_ff;
   logic                advance;

   // Move an item through when the result slot is free or being taken
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   // Hold the timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cs_setup_ticks      <= tws_pkg::CS_SETUP_RESET;
         cfg_ff.half_period_ticks   <= tws_pkg::HALF_PERIOD_RESET;
         cfg_ff.sample_offset_ticks <= tws_pkg::SAMPLE_OFS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tws_pkg::CSR_CS_SETUP:    cfg_ff.cs_setup_ticks      <= csr_wdata;
            tws_pkg::CSR_HALF_PERIOD: cfg_ff.half_period_ticks   <= csr_wdata;
            tws_pkg::CSR_SAMPLE_OFS:  cfg_ff.sample_offset_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Capture accepted input transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= req_tdata[19:0];
      end
   end

   tws_step u_step (
      .cur  (state_ff),
      .item (item_ff),
      .cfg  (cfg_ff),
      .nxt  (state_in),
      .res  (result_in)
   );

   // Advance the sequencer state once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= tws_pkg::PH_IDLE;
         state_ff.tick_count <= 8'd0;
         state_ff.bit_count  <= 4'd0;
         state_ff.out_shift  <= 16'd0;
         state_ff.in_shift   <= 8'd0;
         state_ff.is_read    <= 1'b0;
         state_ff.mute_level <= 1'b1;
         state_ff.last_read  <= 8'd0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register: load on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff};

`ifndef SYNTHESIS
   // Idle sequencer always has a cleared tick counter
   a_idle_tick_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == tws_pkg::PH_IDLE) |-> (state_ff.tick_count == 8'd0))
      else $error("tick counter nonzero while idle");

   // Receive phases never count past the last read bit
   a_recv_bits : assert property (@(posedge clock) disable iff (reset)
      ((state_ff.phase == tws_pkg::PH_RECV_LO) || (state_ff.phase == tws_pkg::PH_RECV_HI))
      |-> (state_ff.bit_count[3] == 1'b0))
      else $error("read bit count out of range");

   // Without a start command an idle sequencer stays idle
   a_idle_holds : assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff.phase == tws_pkg::PH_IDLE &&
       item_ff.command != tws_pkg::CMD_WRITE && item_ff.command != tws_pkg::CMD_READ)
      |=> (state_ff.phase == tws_pkg::PH_IDLE))
      else $error("sequencer left idle without a start command");

   // A finished read is reported while the transfer still shows busy
   a_done_busy : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.read_done) |-> (result_ff.busy_res && !result_ff.chip_select_n))
      else $error("read done outside a transfer");
`endif

endmodule

>>> sv/tws_step.sv
// One-tick step of the serial sequencer: next state and line levels.
module tws_step (
   input  tws_pkg::state_type  cur,
   input  tws_pkg::item_type   item,
   input  tws_pkg::cfg_type    cfg,
   output tws_pkg::state_type  nxt,
   output tws_pkg::result_type res
);

   always_comb begin
      tws_pkg::state_type st;
      logic [7:0] half;
      logic [7:0] len;
      logic [7:0] at;
      logic       ends;
      logic [4:0] bits_next;
      logic [4:0] total;
      logic       done;
      logic [2:0] pos;

      st   = cur;
      done = 1'b0;
      half = tws_pkg::at_least_one(cfg.half_period_ticks);

      // Apply the command
      case (item.command)
         tws_pkg::CMD_MUTE: begin
            st.mute_level = 1'b0;
         end
         tws_pkg::CMD_UNMUTE: begin
            st.mute_level = 1'b1;
         end
         tws_pkg::CMD_WRITE, tws_pkg::CMD_READ: begin
            if (cur.phase == tws_pkg::PH_IDLE) begin
               st.is_read = (item.command == tws_pkg::CMD_READ);
               if (item.command == tws_pkg::CMD_READ) begin
                  st.out_shift = {item.reg_addr | tws_pkg::RD_SET_MASK, 8'd0};
               end else begin
                  st.out_shift = {item.reg_addr & tws_pkg::WR_CLEAR_MASK, item.write_data};
               end
               st.in_shift   = 8'd0;
               st.bit_count  = 4'd0;
               st.tick_count = 8'd0;
               st.phase      = tws_pkg::PH_SETUP;
            end
         end
         default: begin
         end
      endcase

      // Line levels for this tick
      res.chip_select_n = (st.phase == tws_pkg::PH_IDLE);
      res.busy_res      = (st.phase != tws_pkg::PH_IDLE);
      res.serial_clock  = (st.phase == tws_pkg::PH_SEND_HI) ||
                          (st.phase == tws_pkg::PH_DUMMY_HI) ||
                          (st.phase == tws_pkg::PH_RECV_HI);
      res.serial_out    = ((st.phase == tws_pkg::PH_SEND_LO) ||
                           (st.phase == tws_pkg::PH_SEND_HI)) & st.out_shift[15];
      res.serial_drive  = (st.phase < tws_pkg::PH_DUMMY_LO);
      res.mute_n        = st.mute_level;

      // Sample the data line in a read bit's low half
      at  = (cfg.sample_offset_ticks < half) ? cfg.sample_offset_ticks : half - 8'd1;
      pos = ~st.bit_count[2:0];
      if (st.phase == tws_pkg::PH_RECV_LO && st.tick_count == at) begin
         st.in_shift[pos] = item.serial_in;
      end

      // Advance the tick counter within the current stretch
      len  = (st.phase == tws_pkg::PH_SETUP) ? tws_pkg::at_least_one(cfg.cs_setup_ticks) : half;
      ends = tws_pkg::stretch_end(st.tick_count, len);
      bits_next = {1'b0, st.bit_count} + 5'd1;
      total     = st.is_read ? tws_pkg::READ_BITS : tws_pkg::WRITE_BITS;

      if (st.phase == tws_pkg::PH_IDLE || ends) begin
         st.tick_count = 8'd0;
      end else begin
         st.tick_count = st.tick_count + 8'd1;
      end

      // Step the phase sequence
      case (st.phase)
         tws_pkg::PH_SETUP: begin
            if (ends) st.phase = tws_pkg::PH_SEND_LO;
         end
         tws_pkg::PH_SEND_LO: begin
            if (ends) st.phase = tws_pkg::PH_SEND_HI;
         end
         tws_pkg::PH_SEND_HI: begin
            if (ends) begin
               st.out_shift = {st.out_shift[14:0], 1'b0};
               if (bits_next >= total) begin
                  st.bit_count = 4'd0;
                  st.phase     = st.is_read ? tws_pkg::PH_DUMMY_LO : tws_pkg::PH_IDLE;
               end else begin
                  st.bit_count = bits_next[3:0];
                  st.phase     = tws_pkg::PH_SEND_LO;
               end
            end
         end
         tws_pkg::PH_DUMMY_LO: begin
            if (ends) st.phase = tws_pkg::PH_DUMMY_HI;
         end
         tws_pkg::PH_DUMMY_HI: begin
            if (ends) begin
               st.bit_count = 4'd0;
               st.phase     = tws_pkg::PH_RECV_LO;
            end
         end
         tws_pkg::PH_RECV_LO: begin
            if (ends) st.phase = tws_pkg::PH_RECV_HI;
         end
         tws_pkg::PH_RECV_HI: begin
            if (ends) begin
               if (bits_next >= tws_pkg::READ_BITS) begin
                  st.bit_count = 4'd0;
                  st.last_read = st.in_shift;
                  done         = 1'b1;
                  st.phase     = tws_pkg::PH_IDLE;
               end else begin
                  st.bit_count = bits_next[3:0];
                  st.phase     = tws_pkg::PH_RECV_LO;
               end
            end
         end
         default: begin
            st.phase = tws_pkg::PH_IDLE;
         end
      endcase

      res.read_data = st.last_read;
      res.read_done = done;
      nxt           = st;
   end

endmodule

>>> tb/three_wire_serial_register_master_tb.sv
// Self-checking testbench for the three-wire serial register master stream block.
module three_wire_serial_register_master_tb;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;     // command[2:0], reg_addr[10:3], write_data[18:11],
                                    // serial_in[19], zero fill [23:20]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // chip_select_n[0], serial_clock[1], serial_out[2],
                                    // serial_drive[3], mute_n[4], busy_res[5],
                                    // read_data[13:6], read_done[14], zero fill [15]
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   three_wire_serial_register_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Ticks waiting to be driven and line levels waiting to be seen
   tws_pkg::item_type   pending_ticks[$];
   tws_pkg::result_type expected_lines[$];
   tws_pkg::item_type   driven_tick = '0;
   int                  idle_pct = 34;
   int                  mismatches = 0;

   // Timing settings as the sequencer currently sees them
   logic [7:0] cfg_cs;
   logic [7:0] cfg_half;
   logic [7:0] cfg_ofs;

   // Sequencer state mirrored by the predictor
   logic [2:0]  seq_phase;
   logic [7:0]  seq_ticks;
   logic [4:0]  seq_bits;
   logic [15:0] tx_word;
   logic [7:0]  rx_byte;
   logic        rd_mode;
   logic        mute_lvl;
   logic [7:0]  rd_latch;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the tick counter within a stretch; true when the stretch closes
   function automatic logic span_over(input logic [7:0] len);
      logic [7:0] n;
      n = (len == 8'd0) ? 8'd1 : len;
      if ({1'b0, seq_ticks} + 9'd1 >= {1'b0, n}) begin
         seq_ticks = 8'd0;
         return 1'b1;
      end
      seq_ticks = seq_ticks + 8'd1;
      return 1'b0;
   endfunction

   // Line levels for one tick, advancing the mirrored sequencer
   function automatic tws_pkg::result_type master_tick(input tws_pkg::item_type it);
      tws_pkg::result_type r;
      logic [7:0] half;
      logic [7:0] at;
      logic [4:0] total;
      r = '0;
      r.chip_select_n = 1'b1;
      r.serial_drive  = 1'b1;
      half = (cfg_half == 8'd0) ? 8'd1 : cfg_half;

      // Apply the command before the levels are taken
      if (it.command == tws_pkg::CMD_MUTE) begin
         mute_lvl = 1'b0;
      end else if (it.command == tws_pkg::CMD_UNMUTE) begin
         mute_lvl = 1'b1;
      end else if ((it.command == tws_pkg::CMD_WRITE || it.command == tws_pkg::CMD_READ) &&
                   seq_phase == tws_pkg::PH_IDLE) begin
         rd_mode = (it.command == tws_pkg::CMD_READ);
         if (rd_mode)
            tx_word = {it.reg_addr | tws_pkg::RD_SET_MASK, 8'h00};
         else
            tx_word = {it.reg_addr & tws_pkg::WR_CLEAR_MASK, it.write_data};
         rx_byte   = 8'h00;
         seq_bits  = 5'd0;
         seq_ticks = 8'd0;
         seq_phase = tws_pkg::PH_SETUP;
      end

      // Line levels for the current phase
      if (seq_phase != tws_pkg::PH_IDLE) begin
         r.chip_select_n = 1'b0;
         r.busy_res      = 1'b1;
      end
      if (seq_phase == tws_pkg::PH_SEND_HI || seq_phase == tws_pkg::PH_DUMMY_HI ||
          seq_phase == tws_pkg::PH_RECV_HI)
         r.serial_clock = 1'b1;
      if (seq_phase == tws_pkg::PH_SEND_LO || seq_phase == tws_pkg::PH_SEND_HI)
         r.serial_out = tx_word[15];
      if (seq_phase >= tws_pkg::PH_DUMMY_LO)
         r.serial_drive = 1'b0;

      // Advance the sequencer
      case (seq_phase)
         tws_pkg::PH_SETUP: begin
            if (span_over(cfg_cs)) seq_phase = tws_pkg::PH_SEND_LO;
         end
         tws_pkg::PH_SEND_LO: begin
            if (span_over(half)) seq_phase = tws_pkg::PH_SEND_HI;
         end
         tws_pkg::PH_SEND_HI: begin
            if (span_over(half)) begin
               total    = rd_mode ? tws_pkg::READ_BITS : tws_pkg::WRITE_BITS;
               tx_word  = tx_word << 1;
               seq_bits = seq_bits + 5'd1;
               if (seq_bits >= total) begin
                  seq_bits  = 5'd0;
                  seq_phase = rd_mode ? tws_pkg::PH_DUMMY_LO : tws_pkg::PH_IDLE;
               end else begin
                  seq_phase = tws_pkg::PH_SEND_LO;
               end
            end
         end
         tws_pkg::PH_DUMMY_LO: begin
            if (span_over(half)) seq_phase = tws_pkg::PH_DUMMY_HI;
         end
         tws_pkg::PH_DUMMY_HI: begin
            if (span_over(half)) begin
               seq_bits  = 5'd0;
               seq_phase = tws_pkg::PH_RECV_LO;
            end
         end
         tws_pkg::PH_RECV_LO: begin
            // A late offset samples on the last low tick
            at = (cfg_ofs < half) ? cfg_ofs : half - 8'd1;
            if (seq_ticks == at) rx_byte[3'd7 - seq_bits[2:0]] = it.serial_in;
            if (span_over(half)) seq_phase = tws_pkg::PH_RECV_HI;
         end
         tws_pkg::PH_RECV_HI: begin
            if (span_over(half)) begin
               seq_bits = seq_bits + 5'd1;
               if (seq_bits >= tws_pkg::READ_BITS) begin
                  seq_bits    = 5'd0;
                  rd_latch    = rx_byte;
                  r.read_done = 1'b1;
                  seq_phase   = tws_pkg::PH_IDLE;
               end else begin
                  seq_phase = tws_pkg::PH_RECV_LO;
               end
            end
         end
         default: begin
            seq_phase = tws_pkg::PH_IDLE;
            seq_ticks = 8'd0;
         end
      endcase

      r.mute_n    = mute_lvl;
      r.read_data = rd_latch;
      return r;
   endfunction

   // Random tick: mostly plain ticks, with starts, mute changes and unused codes
   function automatic tws_pkg::item_type random_tick();
      tws_pkg::item_type it;
      int p;
      p = $urandom_range(99);
      if (p < 84)      it.command = tws_pkg::CMD_TICK;
      else if (p < 90) it.command = tws_pkg::CMD_WRITE;
      else if (p < 96) it.command = tws_pkg::CMD_READ;
      else if (p < 98) it.command = tws_pkg::CMD_MUTE;
      else if (p < 99) it.command = tws_pkg::CMD_UNMUTE;
      else             it.command = 3'($urandom_range(7, 5));
      it.reg_addr   = 8'($urandom_range(255));
      it.write_data = 8'($urandom_range(255));
      it.serial_in  = 1'($urandom_range(1));
      return it;
   endfunction

   task automatic queue_tick(input logic [2:0] cmd, input logic [7:0] addr,
                             input logic [7:0] data, input logic sin);
      tws_pkg::item_type it;
      it.command    = cmd;
      it.reg_addr   = addr;
      it.write_data = data;
      it.serial_in  = sin;
      pending_ticks.push_back(it);
   endtask

   task automatic queue_random(input int n);
      repeat (n) pending_ticks.push_back(random_tick());
   endtask

   // Hold until every driven tick has come back as line levels
   task automatic settle();
      while (pending_ticks.size() != 0 || req_tvalid || expected_lines.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all three timing registers back to back
   task automatic program_timing(input logic [7:0] cs, input logic [7:0] half,
                                 input logic [7:0] ofs);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= tws_pkg::CSR_CS_SETUP;
      csr_wdata <= cs;
      @(posedge clock);
      csr_index <= tws_pkg::CSR_HALF_PERIOD;
      csr_wdata <= half;
      @(posedge clock);
      csr_index <= tws_pkg::CSR_SAMPLE_OFS;
      csr_wdata <= ofs;
      @(posedge clock);
      csr_we   <= 1'b0;
      cfg_cs   = cs;
      cfg_half = half;
      cfg_ofs  = ofs;
   endtask

   // Drive ticks, predicting line levels for each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_lines.push_back(master_tick(driven_tick));
         if (!req_tvalid || req_tready) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
               driven_tick <= pending_ticks[0];
               req_tdata   <= {4'b0000, pending_ticks.pop_front()};
               req_tvalid  <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      tws_pkg::result_type got;
      tws_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = tws_pkg::result_type'(rsp_tdata[14:0]);
         if (expected_lines.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transaction: %h", rsp_tdata);
         end else begin
            want = expected_lines.pop_front();
            if (got.chip_select_n !== want.chip_select_n ||
                got.serial_clock  !== want.serial_clock  ||
                got.serial_out    !== want.serial_out    ||
                got.serial_drive  !== want.serial_drive  ||
                got.mute_n        !== want.mute_n        ||
                got.busy_res      !== want.busy_res      ||
                got.read_data     !== want.read_data     ||
                got.read_done     !== want.read_done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"line mismatch cs_n/clk/out/drv/mute_n/busy/rdata/done:",
                            " exp %b %b %b %b %b %b %h %b, got %b %b %b %b %b %b %h %b"},
                           want.chip_select_n, want.serial_clock, want.serial_out,
                           want.serial_drive, want.mute_n, want.busy_res,
                           want.read_data, want.read_done,
                           got.chip_select_n, got.serial_clock, got.serial_out,
                           got.serial_drive, got.mute_n, got.busy_res,
                           got.read_data, got.read_done);
            end
         end
      end
   end

   // Stimulus phases
   initial begin
      cfg_cs    = tws_pkg::CS_SETUP_RESET;
      cfg_half  = tws_pkg::HALF_PERIOD_RESET;
      cfg_ofs   = tws_pkg::SAMPLE_OFS_RESET;
      seq_phase = tws_pkg::PH_IDLE;
      seq_ticks = '0;
      seq_bits  = '0;
      tx_word   = '0;
      rx_byte   = '0;
      rd_mode   = 1'b0;
      mute_lvl  = 1'b1;
      rd_latch  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset timing, random traffic
      queue_random(100);
      settle();

      // Fastest timing: mute handling, ignored starts, unused codes, both transfers
      program_timing(8'd1, 8'd1, 8'd0);
      queue_tick(tws_pkg::CMD_MUTE, 8'h00, 8'h00, 1'b0);
      queue_tick(tws_pkg::CMD_UNMUTE, 8'hFF, 8'hFF, 1'b1);
      queue_tick(tws_pkg::CMD_MUTE, 8'h00, 8'h00, 1'b0);
      queue_tick(tws_pkg::CMD_WRITE, 8'hFF, 8'h00, 1'b1);
      queue_random(3);
      queue_tick(tws_pkg::CMD_WRITE, 8'h00, 8'hFF, 1'b0);
      queue_tick(3'd5, 8'hFF, 8'hFF, 1'b1);
      queue_tick(3'd6, 8'h00, 8'h00, 1'b0);
      queue_tick(3'd7, 8'hFF, 8'hFF, 1'b1);
      queue_tick(tws_pkg::CMD_UNMUTE, 8'h00, 8'h00, 1'b0);
      repeat (26) queue_tick(tws_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0);
      queue_tick(tws_pkg::CMD_READ, 8'h00, 8'hFF, 1'b0);
      for (int i = 0; i < 36; i++)
         queue_tick((i == 10) ? tws_pkg::CMD_READ : tws_pkg::CMD_TICK, 8'h00, 8'h00, 1'(i));
      queue_tick(tws_pkg::CMD_READ, 8'hFF, 8'h00, 1'b1);
      repeat (36) queue_tick(tws_pkg::CMD_TICK, 8'hFF, 8'hFF, 1'b1);
      queue_tick(tws_pkg::CMD_WRITE, 8'h5A, 8'hA5, 1'b0);
      repeat (34) queue_tick(tws_pkg::CMD_TICK, 8'h00, 8'h00, 1'b0);
      settle();

      // Zero timing and a sample offset beyond the low half
      program_timing(8'd0, 8'd0, 8'd255);
      queue_random(100);
      settle();

      // Slowest clock; the read is left mid-transfer for the next setting
      program_timing(8'd3, 8'd255, 8'd255);
      queue_tick(tws_pkg::CMD_READ, 8'h81, 8'h00, 1'b1);
      queue_random(150);
      settle();

      // Longest setup, counters already past the new half period
      program_timing(8'd255, 8'd1, 8'd0);
      queue_random(150);
      settle();

      // No idling on either side
      idle_pct = 0;
      program_timing(8'd2, 8'd3, 8'd1);
      queue_random(100);
      settle();
      idle_pct = 34;

      program_timing(8'd1, 8'd2, 8'd2);
      queue_random(100);
      settle();

      program_timing(8'd4, 8'd6, 8'd5);
      queue_random(50);
      settle();
      repeat (10) @(posedge clock);

      if (mismatches == 0 && expected_lines.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #1_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
